// ===== hw/rtl/dctii_pkg.sv =====
package dctii_pkg;

  // Block length and derived widths.
  localparam int LENGTH   = 64;
  localparam int IDX_W    = (LENGTH > 1) ? $clog2(LENGTH) : 1;
  localparam int M_W      = $clog2(4 * LENGTH);
  localparam int SAMPLE_W = 16;
  localparam int COS_W    = 16;
  localparam int PROD_W   = SAMPLE_W + COS_W;
  // Each product stays below 2^30 in magnitude, so LENGTH of them fit here.
  localparam int ACC_W    = 31 + IDX_W;
  localparam int SCALE_W  = 16;
  localparam int SPROD_W  = ACC_W + SCALE_W + 1;
  localparam int COEF_W   = 20;
  localparam int INDEX_W  = 6;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 32;

  localparam int COEF_MAX = 262144;
  localparam int COEF_MIN = -262144;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LENGTH - 1);
  localparam logic [M_W:0]     ROT      = (M_W + 1)'(4 * LENGTH);

  localparam logic [63:0] PI_Q31  = 64'd6746518852;
  localparam logic [63:0] ONE_Q31 = 64'd2147483648;

  // Reciprocals of the Taylor divisors, rounded up at 2^39. Every numerator stays
  // below 2^31 and every divisor below 2^8, so the product shifted down by 39 is
  // exactly the truncated quotient.
  localparam int          RCP_SHIFT = 39;
  localparam logic [63:0] RCP_ONE   = 64'd1 << RCP_SHIFT;
  localparam logic [63:0] SIN_RCP [7] = '{
    (RCP_ONE + 64'd5) / 64'd6,     (RCP_ONE + 64'd19) / 64'd20,
    (RCP_ONE + 64'd41) / 64'd42,   (RCP_ONE + 64'd71) / 64'd72,
    (RCP_ONE + 64'd109) / 64'd110, (RCP_ONE + 64'd155) / 64'd156,
    (RCP_ONE + 64'd209) / 64'd210
  };
  localparam logic [63:0] COS_RCP [7] = '{
    (RCP_ONE + 64'd1) / 64'd2,     (RCP_ONE + 64'd11) / 64'd12,
    (RCP_ONE + 64'd29) / 64'd30,   (RCP_ONE + 64'd55) / 64'd56,
    (RCP_ONE + 64'd89) / 64'd90,   (RCP_ONE + 64'd131) / 64'd132,
    (RCP_ONE + 64'd181) / 64'd182
  };

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_MAC,
    ST_WAIT,
    ST_EMIT
  } state_e;

  // Control that travels with one sample/cosine pair through the MAC pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic dc;
  } mac_ctl_t;

  typedef logic signed [COS_W-1:0] cos_rom_t [4*LENGTH];

  // Quotient by a small divisor, given as its reciprocal.
  function automatic logic [63:0] div_rcp(input logic [63:0] a, input logic [63:0] rcp);
    logic [127:0] p;
    p = 128'(a) * 128'(rcp);
    return 64'(p >> RCP_SHIFT);
  endfunction

  // Q31 cosine or sine of pi*r/(2*LENGTH) by a truncated Taylor series.
  function automatic logic [63:0] series_q31(input logic [63:0] r, input logic want_sin);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    x    = (PI_Q31 * r) / (2 * LENGTH);
    x2   = (x * x) >> 31;
    term = want_sin ? x : ONE_Q31;
    acc  = $signed(term);
    for (int i = 0; i < 7; i++) begin
      term = div_rcp((term * x2) >> 31, want_sin ? SIN_RCP[i] : COS_RCP[i]);
      if (i[0] == 1'b0) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = '0;
    end
    return acc;
  endfunction

  // Q1.15 cosine of pi*m/(2*LENGTH), folded by quadrant into [0, pi/4].
  function automatic logic signed [COS_W-1:0] cos_q15(input logic [63:0] m);
    logic [63:0] quad;
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] q;
    logic        want_sin;
    logic        negative;
    quad     = m / LENGTH;
    r        = m % LENGTH;
    want_sin = quad[0];
    negative = (quad == 64'd1) || (quad == 64'd2);
    if (2 * r > LENGTH) begin
      r        = LENGTH - r;
      want_sin = !want_sin;
    end
    v = series_q31(r, want_sin);
    q = (v + 64'd32768) >> 16;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return negative ? COS_W'(-q) : COS_W'(q);
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    for (int m = 0; m < 4 * LENGTH; m++) begin
      rom[m] = cos_q15(64'(m));
    end
    return rom;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_q;
    logic [63:0] rem;
    res   = '0;
    bit_q = 64'd1 << 62;
    rem   = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_q) begin
        rem = rem - (res + bit_q);
        res = (res >> 1) + bit_q;
      end else begin
        res = res >> 1;
      end
      bit_q = bit_q >> 2;
    end
    return res;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

  localparam logic [SCALE_W-1:0] SCALE_AC = SCALE_W'(isqrt64((64'd1 << 31) / LENGTH));
  localparam logic [SCALE_W-1:0] SCALE_DC = SCALE_W'(isqrt64((64'd1 << 30) / LENGTH));

endpackage

// ===== hw/rtl/dctii_mac.sv =====
// Shared multiply-accumulate unit with the final scale, rounding and saturation.
module dctii_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  dctii_pkg::mac_ctl_t                   ctl_i,
  input  logic signed [dctii_pkg::SAMPLE_W-1:0] sample_i,
  input  logic signed [dctii_pkg::COS_W-1:0]    cos_i,
  output logic                                  done_o,
  output logic signed [dctii_pkg::COEF_W-1:0]   coef_o
);

  localparam int RQ_W = (dctii_pkg::SPROD_W - 30 > 21) ? dctii_pkg::SPROD_W - 30 : 21;
  localparam logic signed [dctii_pkg::SPROD_W-1:0] HALF =
    dctii_pkg::SPROD_W'(64'd1 << 29);

  logic signed [dctii_pkg::PROD_W-1:0]  prod_q;
  dctii_pkg::mac_ctl_t                  ctl1_q;
  logic signed [dctii_pkg::ACC_W-1:0]   acc_q;
  logic                                 acc_done_q;
  logic                                 acc_dc_q;
  logic signed [dctii_pkg::SPROD_W-1:0] sprod_q;
  logic                                 done_q;
  logic signed [dctii_pkg::SCALE_W:0]   scale;
  logic signed [dctii_pkg::SPROD_W-1:0] rnd;
  logic signed [RQ_W-1:0]               rq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q     <= '0;
      acc_done_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      ctl1_q     <= ctl_i;
      acc_done_q <= ctl1_q.valid && ctl1_q.last;
      done_q     <= acc_done_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= sample_i * cos_i;
    if (ctl1_q.valid) begin
      acc_q    <= ctl1_q.first ? dctii_pkg::ACC_W'(prod_q)
                               : acc_q + dctii_pkg::ACC_W'(prod_q);
      acc_dc_q <= ctl1_q.dc;
    end
    if (acc_done_q) begin
      sprod_q <= dctii_pkg::SPROD_W'(acc_q) * dctii_pkg::SPROD_W'(scale);
    end
  end

  always_comb begin
    scale = $signed({1'b0, acc_dc_q ? dctii_pkg::SCALE_DC : dctii_pkg::SCALE_AC});
    rnd   = sprod_q + HALF;
    rq    = RQ_W'(rnd >>> 30);
    if (rq > $signed(RQ_W'(dctii_pkg::COEF_MAX))) begin
      coef_o = dctii_pkg::COEF_W'(dctii_pkg::COEF_MAX);
    end else if (rq < $signed(RQ_W'(dctii_pkg::COEF_MIN))) begin
      coef_o = dctii_pkg::COEF_W'(dctii_pkg::COEF_MIN);
    end else begin
      coef_o = dctii_pkg::COEF_W'(rq);
    end
  end

  assign done_o = done_q;

endmodule

// ===== hw/rtl/dct_ii_orthonormal_block.sv =====
// Orthonormal DCT-II over blocks of LENGTH signed 16-bit samples.
// Samples arrive on the slave stream, one request per sample, in time order.
// The block takes one sample per cycle until it holds LENGTH of them; the
// request that delivers the last sample of a block starts the transform.
// While the transform runs, s_axis_tready_o is low.
// Each coefficient k is a sum of LENGTH products of a sample and a Q1.15
// cosine from a constant table, formed by one shared multiplier and
// accumulator that take one product per cycle, followed by a scale multiply,
// round to nearest and saturation to [-262144, 262144].
// Each coefficient takes LENGTH products plus the pipeline of the
// multiply-accumulate unit, and the next one starts only after it is emitted, so
// the single multiplier sets how fast the LENGTH coefficients of a block leave.
// Coefficients leave on the master stream in order k = 0 .. LENGTH-1, with
// tlast on the final one. An output register holds the waiting coefficient,
// so the next one is computed while the receiver stalls; a finished result only
// waits when it would overwrite a request not yet taken.
// After the last coefficient is registered, the block accepts samples of the
// next block at once. Reset empties the sample count and the output register;
// the sample memory keeps no reset value and needs none.
module dct_ii_orthonormal_block (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [15:0] sample
  input  logic [dctii_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [19:0] coefficient, [25:20] coeff_index, [31:26] zero
  output logic [dctii_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  output logic                                m_axis_tlast_o
);

  dctii_pkg::state_e state_q, state_d;

  logic [dctii_pkg::IDX_W-1:0] fill_q, fill_d;
  logic [dctii_pkg::IDX_W-1:0] n_q, n_d;
  logic [dctii_pkg::IDX_W-1:0] k_q, k_d;
  logic [dctii_pkg::M_W-1:0]   m_q, m_d;
  logic [dctii_pkg::M_W:0]     m_sum;
  logic [dctii_pkg::M_W-1:0]   m_next;

  logic [dctii_pkg::SAMPLE_W-1:0]      mem [dctii_pkg::LENGTH];
  logic signed [dctii_pkg::SAMPLE_W-1:0] x_q;
  logic signed [dctii_pkg::COS_W-1:0]  cos_q;
  dctii_pkg::mac_ctl_t                 ctl_q, ctl_d;

  logic                                res_valid;
  logic signed [dctii_pkg::COEF_W-1:0] res_coef;

  logic                                out_valid_q;
  logic [dctii_pkg::COEF_W-1:0]        out_coef_q;
  logic [dctii_pkg::INDEX_W-1:0]       out_idx_q;
  logic                                out_last_q;

  logic in_take;
  logic slot_free;
  logic emit_load;

  assign in_take   = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free = !out_valid_q || m_axis_tready_i;

  // Phase of the cosine for sample n steps by 2k, modulo four quarter periods.
  always_comb begin
    m_sum  = {1'b0, m_q} + ((dctii_pkg::M_W + 1)'(k_q) << 1);
    m_next = (m_sum >= dctii_pkg::ROT) ? dctii_pkg::M_W'(m_sum - dctii_pkg::ROT)
                                       : dctii_pkg::M_W'(m_sum);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dctii_pkg::ST_LOAD: begin
        if (in_take && fill_q == dctii_pkg::LAST_IDX) begin
          state_d = dctii_pkg::ST_MAC;
        end
      end
      dctii_pkg::ST_MAC: begin
        if (n_q == dctii_pkg::LAST_IDX) begin
          state_d = dctii_pkg::ST_WAIT;
        end
      end
      dctii_pkg::ST_WAIT: begin
        if (res_valid) begin
          state_d = dctii_pkg::ST_EMIT;
        end
      end
      dctii_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_d = (k_q == dctii_pkg::LAST_IDX) ? dctii_pkg::ST_LOAD : dctii_pkg::ST_MAC;
        end
      end
      default: state_d = dctii_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    fill_d          = fill_q;
    n_d             = n_q;
    k_d             = k_q;
    m_d             = m_q;
    ctl_d           = '0;
    emit_load       = 1'b0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      dctii_pkg::ST_LOAD: begin
        s_axis_tready_o = 1'b1;
        if (in_take) begin
          fill_d = (fill_q == dctii_pkg::LAST_IDX) ? '0 : fill_q + 1'b1;
          n_d    = '0;
          m_d    = '0;
        end
      end
      dctii_pkg::ST_MAC: begin
        ctl_d.valid = 1'b1;
        ctl_d.first = (n_q == '0);
        ctl_d.last  = (n_q == dctii_pkg::LAST_IDX);
        ctl_d.dc    = (k_q == '0);
        n_d         = n_q + 1'b1;
        m_d         = m_next;
      end
      dctii_pkg::ST_WAIT: begin
      end
      dctii_pkg::ST_EMIT: begin
        if (slot_free) begin
          emit_load = 1'b1;
          if (k_q == dctii_pkg::LAST_IDX) begin
            k_d = '0;
          end else begin
            k_d = k_q + 1'b1;
            n_d = '0;
            m_d = dctii_pkg::M_W'(k_q) + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dctii_pkg::ST_LOAD;
      fill_q      <= '0;
      n_q         <= '0;
      k_q         <= '0;
      m_q         <= '0;
      ctl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      n_q     <= n_d;
      k_q     <= k_d;
      m_q     <= m_d;
      ctl_q   <= ctl_d;
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sample memory with a registered read port, and the registered table lookup.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mem[fill_q] <= s_axis_tdata_i[dctii_pkg::SAMPLE_W-1:0];
    end
    x_q   <= mem[n_q];
    cos_q <= dctii_pkg::COS_ROM[m_q];
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_coef_q <= res_coef;
      out_idx_q  <= dctii_pkg::INDEX_W'(k_q);
      out_last_q <= (k_q == dctii_pkg::LAST_IDX);
    end
  end

  dctii_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_q),
    .sample_i(x_q),
    .cos_i   (cos_q),
    .done_o  (res_valid),
    .coef_o  (res_coef)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(dctii_pkg::M_TDATA_W - dctii_pkg::COEF_W - dctii_pkg::INDEX_W)'(0),
                            out_idx_q, out_coef_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef NO_ASSERTIONS
  // A finished sum only arrives while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> state_q == dctii_pkg::ST_WAIT)
    else $error("coefficient finished outside the wait state");

  // The cosine phase stays inside one full period.
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, m_q} < dctii_pkg::ROT)
    else $error("cosine phase out of range");

  // The final coefficient of a block carries the highest index.
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> out_idx_q == dctii_pkg::INDEX_W'(dctii_pkg::LENGTH - 1))
    else $error("last flag on wrong coefficient index");

  // A new transform starts from the first sample and the first frequency.
  a_block_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dctii_pkg::ST_MAC && $past(state_q) == dctii_pkg::ST_LOAD
      |-> n_q == '0 && k_q == '0 && fill_q == '0)
    else $error("transform started with stale counters");
`endif

endmodule
